// ===== rtl/ubtrq_pkg.sv =====
// ----------------------------------------------------------------------------
// ubtrq_pkg
// Shared types for the buffered UART transmit/receive queues.
// ----------------------------------------------------------------------------
package ubtrq_pkg;

    localparam int unsigned ByteW = 8;

    typedef logic [ByteW-1:0] t_byte;

    typedef enum logic [1:0] {
        REQ_PUSH_TX  = 2'd0,
        REQ_POP_RX   = 2'd1,
        REQ_LINE_RX  = 2'd2,
        REQ_TX_EMPTY = 2'd3
    } t_req;

    // Occupancy flags that a ring reports before the current word is applied.
    typedef struct packed {
        logic empty;
        logic full;
    } t_ring_stat;

endpackage

// ===== rtl/ubtrq_ram.sv =====
// ----------------------------------------------------------------------------
// ubtrq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ubtrq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ubtrq_ring.sv =====
// ----------------------------------------------------------------------------
// ubtrq_ring
// One byte ring queue: head and tail pointers around a RAM. One slot stays
// free so that full and empty can be told apart.
// ----------------------------------------------------------------------------
module ubtrq_ring #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ubtrq_pkg::t_byte      i_data,
    input  logic                  i_pop,
    output ubtrq_pkg::t_ring_stat o_stat,
    output ubtrq_pkg::t_byte      o_rdata
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [AW-1:0] w_head_adv, w_tail_adv;
    logic          w_we;

    always_comb begin
        w_head_adv = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        w_tail_adv = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
    end

    assign o_stat.empty   = (r_head == r_tail);
    assign o_stat.full    = (w_head_adv == r_tail);
    assign w_we           = i_push && !o_stat.full;

    always_comb begin
        n_head = w_we ? w_head_adv : r_head;
        n_tail = i_pop ? w_tail_adv : r_tail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    ubtrq_ram #(
        .WIDTH (ubtrq_pkg::ByteW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_head),
        .i_wdata (i_data),
        .i_re    (i_pop),
        .i_raddr (r_tail),
        .o_rdata (o_rdata)
    );

endmodule

// ===== rtl/uart_buffered_tx_rx_queues_core.sv =====
// ----------------------------------------------------------------------------
// uart_buffered_tx_rx_queues_core
// Transmit and receive byte rings between a host and a UART line, with the
// transmitter busy flag and drop-on-full overflow reporting.
// ----------------------------------------------------------------------------
//  Channel  Handshake                      Fields
//  in       i_in_valid / o_in_ready        i_req_type, i_data_byte
//  out      o_out_valid / i_out_ready      o_send_valid, o_send_byte,
//                                          o_read_valid, o_read_byte,
//                                          o_overflow, o_tx_active
//
//  Pointers update and the ring RAM is read in the accept cycle, and the
//  result register loads from the RAM output in the next. One word is in
//  flight at a time. A stalled result holds the input off; a word is
//  accepted in the cycle the previous result is taken. Reset clears
//  pointers and busy; no clearing pass.
// ----------------------------------------------------------------------------
module uart_buffered_tx_rx_queues_core #(
    parameter int unsigned TX_DEPTH = 16,
    parameter int unsigned RX_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_send_valid,
    output logic [7:0] o_send_byte,
    output logic       o_read_valid,
    output logic [7:0] o_read_byte,
    output logic       o_overflow,
    output logic       o_tx_active
);

    ubtrq_pkg::t_ring_stat w_tx_stat, w_rx_stat;
    ubtrq_pkg::t_byte      w_tx_rdata, w_rx_rdata;
    logic                  w_acc;
    logic                  w_tx_push, w_tx_pop, w_rx_push, w_rx_pop;
    logic                  w_send, w_read, w_ovf, w_fwd;

    logic             r_busy, n_busy;
    logic             r_pend;
    logic             r_ov;
    logic             r_p_send, r_p_read, r_p_ovf, r_p_fwd, r_p_busy;
    ubtrq_pkg::t_byte r_p_fwd_byte;
    logic             r_send_valid, r_read_valid, r_ovf_out, r_act_out;
    ubtrq_pkg::t_byte r_send_byte, r_read_byte;

    assign o_in_ready = !r_pend && (!r_ov || i_out_ready);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        w_tx_push = 1'b0;
        w_tx_pop  = 1'b0;
        w_rx_push = 1'b0;
        w_rx_pop  = 1'b0;
        w_send    = 1'b0;
        w_read    = 1'b0;
        w_ovf     = 1'b0;
        w_fwd     = 1'b0;
        n_busy    = r_busy;
        unique case (ubtrq_pkg::t_req'(i_req_type))
            ubtrq_pkg::REQ_PUSH_TX: begin
                w_tx_push = 1'b1;
                w_ovf     = w_tx_stat.full;
                // After a push the ring is never empty, so an idle
                // transmitter always gets a byte. If the ring was empty, that
                // byte is the one being written and bypasses the RAM.
                if (!r_busy) begin
                    w_tx_pop = 1'b1;
                    w_send   = 1'b1;
                    w_fwd    = w_tx_stat.empty;
                    n_busy   = 1'b1;
                end
            end
            ubtrq_pkg::REQ_POP_RX: begin
                if (!w_rx_stat.empty) begin
                    w_rx_pop = 1'b1;
                    w_read   = 1'b1;
                end
            end
            ubtrq_pkg::REQ_LINE_RX: begin
                w_rx_push = 1'b1;
                w_ovf     = w_rx_stat.full;
            end
            ubtrq_pkg::REQ_TX_EMPTY: begin
                if (!w_tx_stat.empty) begin
                    w_tx_pop = 1'b1;
                    w_send   = 1'b1;
                    n_busy   = 1'b1;
                end else begin
                    n_busy   = 1'b0;
                end
            end
            default: begin
                n_busy = r_busy;
            end
        endcase
    end

    ubtrq_ring #(
        .DEPTH (TX_DEPTH)
    ) u_tx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_acc && w_tx_push),
        .i_data  (i_data_byte),
        .i_pop   (w_acc && w_tx_pop),
        .o_stat  (w_tx_stat),
        .o_rdata (w_tx_rdata)
    );

    ubtrq_ring #(
        .DEPTH (RX_DEPTH)
    ) u_rx_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_acc && w_rx_push),
        .i_data  (i_data_byte),
        .i_pop   (w_acc && w_rx_pop),
        .o_stat  (w_rx_stat),
        .o_rdata (w_rx_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (w_acc) begin
                r_busy <= n_busy;
            end
            r_pend <= w_acc;
            if (r_pend) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_p_send     <= w_send;
            r_p_read     <= w_read;
            r_p_ovf      <= w_ovf;
            r_p_fwd      <= w_fwd;
            r_p_fwd_byte <= i_data_byte;
            r_p_busy     <= n_busy;
        end
        if (r_pend) begin
            r_send_valid <= r_p_send;
            r_read_valid <= r_p_read;
            r_ovf_out    <= r_p_ovf;
            r_act_out    <= r_p_busy;
            if (r_p_send) begin
                r_send_byte <= r_p_fwd ? r_p_fwd_byte : w_tx_rdata;
            end else begin
                r_send_byte <= '0;
            end
            r_read_byte  <= r_p_read ? w_rx_rdata : '0;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_send_valid = r_send_valid;
    assign o_send_byte  = r_send_byte;
    assign o_read_valid = r_read_valid;
    assign o_read_byte  = r_read_byte;
    assign o_overflow   = r_ovf_out;
    assign o_tx_active  = r_act_out;

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_pend && !o_in_ready)
        else $error("second word accepted while one is in flight");

    a_send_read_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_send_valid && o_read_valid))
        else $error("send and read both reported for one word");

    a_send_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_send_valid) |-> o_tx_active)
        else $error("byte sent but transmitter not marked busy");

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !(r_ov && $past(r_ov) && !$past(i_out_ready)))
        else $error("result register overwritten before it was taken");
`endif

endmodule
